// File: sv/afr_pkg.sv
// Shared types and constants of the APDU frame reassembler.
// Used by every module of the block; no dependencies.
package afr_pkg;

  localparam int MaxDataBytes = 1024;
  localparam int QueueDepth   = 4;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StHeaderOnly = 3'd1;
  localparam logic [2:0] StUnknownLe  = 3'd2;
  localparam logic [2:0] StMalformed  = 3'd3;
  localparam logic [2:0] StOverflow   = 3'd4;

  localparam logic KindData    = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [3:0] SkipReset = 4'd3;

  // One queue entry: the data write and/or the summary caused by one byte.
  typedef struct packed {
    logic        has_data;
    logic [9:0]  data_index;
    logic [7:0]  data_value;
    logic        has_sum;
    logic [7:0]  class_byte;
    logic [7:0]  instruction_byte;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] command_length;
    logic [16:0] response_length;
    logic [10:0] received_length;
    logic [2:0]  frame_status;
  } afr_entry_t;

  function automatic logic [2:0] raise_status(input logic [2:0] cur, input logic [2:0] code);
    return (code > cur) ? code : cur;
  endfunction

endpackage

// File: sv/apdu_frame_reassembler.sv
// Top level of the APDU frame reassembler: configuration register, front end,
// result queue and back end. Depends on afr_pkg, afr_front, afr_queue, afr_back.
//
// Usage: frame bytes enter on in_valid/in_ready with frame_first, frame_last and
// leading_frame; a transfer takes place when valid and ready are both high.
// Results leave on out_valid/out_ready: result_kind 0 is a data write
// (data_index, data_value), 1 is a frame summary sent with the last byte of a frame.
// A byte gives zero, one or two results; a data write precedes the summary.
// Each result of a byte is registered in the queue and then in the back end's hold
// register before out_valid presents it.
// Throughput: one byte per cycle while the queue is not full; a byte with both a
// data write and a summary holds the single output register for both results in turn.
// A four-entry queue parts front and back, so input keeps flowing while a result
// waits; in_ready drops only once the queue is full under a stalled receiver.
// Register leading_skip_bytes sits at address 0 of the APB port, reset to 3.
// Synchronous reset clears all frame state and empties the queue; no results
// are pending afterward.
module apdu_frame_reassembler #(
  parameter int MAX_DATA_BYTES = afr_pkg::MaxDataBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_first,
  input  logic        frame_last,
  input  logic        leading_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [9:0]  data_index,
  output logic [7:0]  data_value,
  output logic [7:0]  class_byte,
  output logic [7:0]  instruction_byte,
  output logic [7:0]  param_one,
  output logic [7:0]  param_two,
  output logic [15:0] command_length,
  output logic [16:0] response_length,
  output logic [10:0] received_length,
  output logic [2:0]  frame_status,
  output logic        last_of_run
);

  logic [3:0]          leading_skip_bytes;
  logic                q_full;
  logic                q_nonempty;
  logic                q_pop;
  logic                push;
  afr_pkg::afr_entry_t push_entry;
  afr_pkg::afr_entry_t q_head;

  assign pready = 1'b1;
  // one register: every word address decodes to it
  assign prdata = (paddr == 2'd0) ? {28'b0, leading_skip_bytes} : {28'b0, leading_skip_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      leading_skip_bytes <= afr_pkg::SkipReset;
    end else if (psel && penable && pwrite && pready) begin
      leading_skip_bytes <= pwdata[3:0];
    end
  end

  afr_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .skip         (leading_skip_bytes),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_byte   (frame_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last),
    .leading_frame(leading_frame),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  afr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .full      (q_full),
    .head      (q_head)
  );

  afr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_nonempty      (q_nonempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .data_index      (data_index),
    .data_value      (data_value),
    .class_byte      (class_byte),
    .instruction_byte(instruction_byte),
    .param_one       (param_one),
    .param_two       (param_two),
    .command_length  (command_length),
    .response_length (response_length),
    .received_length (received_length),
    .frame_status    (frame_status),
    .last_of_run     (last_of_run)
  );

endmodule

// File: sv/afr_front.sv
// Front end: accepts frame bytes, tracks frame and APDU state, classifies each byte.
// Pushes one queue entry per byte that causes a result. Depends on afr_pkg.
module afr_front #(
  parameter int MAX_DATA_BYTES = afr_pkg::MaxDataBytes
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         skip,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         frame_byte,
  input  logic               frame_first,
  input  logic               frame_last,
  input  logic               leading_frame,
  input  logic               q_full,
  output logic               push,
  output afr_pkg::afr_entry_t push_entry
);

  localparam int CW   = $clog2(MAX_DATA_BYTES + 1);
  localparam int CmpW = (CW > 16) ? CW : 16;

  logic [7:0]    position;
  logic          is_leading;
  logic [31:0]   header;
  logic [15:0]   length_field;
  logic          extended;
  logic [15:0]   lc;
  logic [16:0]   le;
  logic [CW-1:0] stored;
  logic [7:0]    excess;
  logic [15:0]   tail;
  logic [2:0]    status;

  logic [7:0]    pos_c;
  logic          lead_c;
  logic [31:0]   hdr_c;
  logic [15:0]   lf_c;
  logic          ext_c;
  logic [15:0]   lc_c;
  logic [16:0]   le_c;
  logic [CW-1:0] cnt_c;
  logic [7:0]    exc_c;
  logic [15:0]   tail_c;
  logic [2:0]    st_c;

  logic [7:0]    position_next;
  logic [31:0]   header_next;
  logic [15:0]   length_field_next;
  logic          extended_next;
  logic [15:0]   lc_next;
  logic [16:0]   le_next;
  logic [CW-1:0] stored_next;
  logic [7:0]    excess_next;
  logic [15:0]   tail_next;
  logic [2:0]    status_next;

  logic [7:0]    s8;
  logic [1:0]    hidx;
  logic          do_store;
  logic          wr;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign s8       = {4'b0, skip};
  assign hidx     = 2'(pos_c - s8);

  always_comb begin
    pos_c  = position;
    lead_c = is_leading;
    hdr_c  = header;
    lf_c   = length_field;
    ext_c  = extended;
    lc_c   = lc;
    le_c   = le;
    cnt_c  = stored;
    exc_c  = excess;
    tail_c = tail;
    st_c   = status;
    if (frame_first) begin
      pos_c  = '0;
      lead_c = leading_frame;
      exc_c  = '0;
      tail_c = '0;
      st_c   = afr_pkg::StOk;
      if (leading_frame) begin
        hdr_c = '0;
        lf_c  = '0;
        ext_c = 1'b0;
        lc_c  = '0;
        le_c  = '0;
        cnt_c = '0;
      end
    end

    header_next       = hdr_c;
    length_field_next = lf_c;
    extended_next     = ext_c;
    lc_next           = lc_c;
    le_next           = le_c;
    stored_next       = cnt_c;
    excess_next       = exc_c;
    tail_next         = tail_c;
    status_next       = st_c;
    do_store          = 1'b0;
    wr                = 1'b0;

    if (lead_c) begin
      if (pos_c < s8) begin
        if (frame_last) status_next = afr_pkg::raise_status(status_next, afr_pkg::StMalformed);
      end else if (pos_c < s8 + 8'd4) begin
        case (hidx)
          2'd0:    header_next[31:24] = frame_byte;
          2'd1:    header_next[23:16] = frame_byte;
          2'd2:    header_next[15:8]  = frame_byte;
          default: header_next[7:0]   = frame_byte;
        endcase
        if (frame_last) begin
          status_next = afr_pkg::raise_status(status_next,
            (hidx == 2'd3) ? afr_pkg::StHeaderOnly : afr_pkg::StMalformed);
        end
      end else if (pos_c == s8 + 8'd4) begin
        if (frame_byte != 8'h00) begin
          if (frame_last) begin
            le_next = {9'b0, frame_byte};
            lc_next = '0;
          end else begin
            lc_next = {8'b0, frame_byte};
          end
        end else if (frame_last) begin
          // lone zero length byte: short Le of 256
          le_next = 17'd256;
          lc_next = '0;
        end else begin
          extended_next = 1'b1;
        end
      end else if (ext_c && pos_c == s8 + 8'd5) begin
        length_field_next = {frame_byte, 8'h00};
        if (frame_last) status_next = afr_pkg::raise_status(status_next, afr_pkg::StMalformed);
      end else if (ext_c && pos_c == s8 + 8'd6) begin
        length_field_next = {lf_c[15:8], frame_byte};
        if (frame_last) begin
          lc_next = '0;
          le_next = (length_field_next != 16'h0) ? {1'b0, length_field_next} : 17'h10000;
        end else begin
          lc_next = length_field_next;
        end
      end else begin
        do_store = 1'b1;
      end
    end else if (pos_c != 8'd0) begin
      if (CmpW'(cnt_c) < CmpW'(lc_c)) begin
        do_store = 1'b1;
      end else begin
        if (exc_c != 8'hFF) excess_next = exc_c + 8'd1;
        tail_next = {tail_c[7:0], frame_byte};
      end
    end

    if (do_store) begin
      if (cnt_c < CW'(MAX_DATA_BYTES)) begin
        wr          = 1'b1;
        stored_next = cnt_c + CW'(1);
      end else begin
        status_next = afr_pkg::raise_status(status_next, afr_pkg::StOverflow);
      end
    end

    // excess bytes of a continuation frame carry Le
    if (frame_last && !lead_c) begin
      if (excess_next == 8'd1) begin
        le_next = (tail_next[7:0] != 8'h00) ? {9'b0, tail_next[7:0]} : 17'd256;
      end else if (excess_next == 8'd2) begin
        le_next = (tail_next != 16'h0) ? {1'b0, tail_next} : 17'h10000;
      end else if (excess_next > 8'd2) begin
        status_next = afr_pkg::raise_status(status_next, afr_pkg::StUnknownLe);
      end
    end

    position_next = (pos_c != 8'hFF) ? pos_c + 8'd1 : pos_c;
  end

  always_comb begin
    push                        = accept && (wr || frame_last);
    push_entry.has_data         = wr;
    push_entry.data_index       = 10'(cnt_c);
    push_entry.data_value       = frame_byte;
    push_entry.has_sum          = frame_last;
    push_entry.class_byte       = header_next[31:24];
    push_entry.instruction_byte = header_next[23:16];
    push_entry.param_one        = header_next[15:8];
    push_entry.param_two        = header_next[7:0];
    push_entry.command_length   = lc_next;
    push_entry.response_length  = le_next;
    push_entry.received_length  = 11'(stored_next);
    push_entry.frame_status     = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      is_leading   <= 1'b0;
      header       <= '0;
      length_field <= '0;
      extended     <= 1'b0;
      lc           <= '0;
      le           <= '0;
      stored       <= '0;
      excess       <= '0;
      tail         <= '0;
      status       <= afr_pkg::StOk;
    end else if (accept) begin
      position     <= position_next;
      is_leading   <= lead_c;
      header       <= header_next;
      length_field <= length_field_next;
      extended     <= extended_next;
      lc           <= lc_next;
      le           <= le_next;
      stored       <= stored_next;
      excess       <= excess_next;
      tail         <= tail_next;
      status       <= status_next;
    end
  end

endmodule

// File: sv/afr_queue.sv
// Short FIFO of result entries between front and back end.
// Depends on afr_pkg for the entry type and depth.
module afr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afr_pkg::afr_entry_t push_entry,
  input  logic                pop,
  output logic                nonempty,
  output logic                full,
  output afr_pkg::afr_entry_t head
);

  localparam int Depth = afr_pkg::QueueDepth;
  localparam int IW    = $clog2(Depth);

  afr_pkg::afr_entry_t entries [Depth];
  logic [IW-1:0]       wr_ptr;
  logic [IW-1:0]       rd_ptr;
  logic [IW:0]         count;
  logic                do_push;
  logic                do_pop;

  assign nonempty = (count != '0);
  assign full     = (count == (IW+1)'(Depth));
  assign head     = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == IW'(Depth - 1)) ? '0 : wr_ptr + IW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == IW'(Depth - 1)) ? '0 : rd_ptr + IW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (IW+1)'(1);
        2'b01:   count <= count - (IW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/afr_back.sv
// Back end: takes queue entries and delivers their results one transfer per
// cycle while out_ready is high, data write before summary. Depends on afr_pkg.
module afr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nonempty,
  input  afr_pkg::afr_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                result_kind,
  output logic [9:0]          data_index,
  output logic [7:0]          data_value,
  output logic [7:0]          class_byte,
  output logic [7:0]          instruction_byte,
  output logic [7:0]          param_one,
  output logic [7:0]          param_two,
  output logic [15:0]         command_length,
  output logic [16:0]         response_length,
  output logic [10:0]         received_length,
  output logic [2:0]          frame_status,
  output logic                last_of_run
);

  afr_pkg::afr_entry_t hold;
  logic                busy;
  logic                phase;
  logic                is_sum;
  logic                fin;

  assign is_sum    = (phase == afr_pkg::KindSummary);
  assign out_valid = busy;
  assign last_of_run = is_sum || !hold.has_sum;
  // entry done once its final result transfers
  assign fin       = busy && out_ready && last_of_run;
  assign q_pop     = q_nonempty && (!busy || fin);

  assign result_kind      = phase;
  assign data_index       = is_sum ? 10'd0 : hold.data_index;
  assign data_value       = is_sum ? 8'd0 : hold.data_value;
  assign class_byte       = is_sum ? hold.class_byte : 8'd0;
  assign instruction_byte = is_sum ? hold.instruction_byte : 8'd0;
  assign param_one        = is_sum ? hold.param_one : 8'd0;
  assign param_two        = is_sum ? hold.param_two : 8'd0;
  assign command_length   = is_sum ? hold.command_length : 16'd0;
  assign response_length  = is_sum ? hold.response_length : 17'd0;
  assign received_length  = is_sum ? hold.received_length : 11'd0;
  assign frame_status     = is_sum ? hold.frame_status : afr_pkg::StOk;

  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= afr_pkg::KindData;
    end else if (q_pop) begin
      busy  <= 1'b1;
      phase <= q_head.has_data ? afr_pkg::KindData : afr_pkg::KindSummary;
    end else if (fin) begin
      busy  <= 1'b0;
    end else if (busy && out_ready) begin
      phase <= afr_pkg::KindSummary;
    end
  end

endmodule

// File: bench/apdu_frame_reassembler_test.sv
`timescale 1ns / 100ps
// Self-checking bench for apdu_frame_reassembler: directed table, then random APDU traffic.
// Depends on afr_pkg and the RTL of the block; the expected results come from an in-bench predictor.
module apdu_frame_reassembler_test;

  localparam logic [1:0]  SkipAddr    = 2'd0;
  localparam logic [16:0] LeShortZero = 17'd256;
  localparam logic [16:0] LeExtZero   = 17'h10000;
  localparam int          DrainCycles = 8;
  localparam int          HoldCycles  = 300;
  localparam int          TimeoutNs   = 1000000;

  typedef struct packed {
    logic        kind;
    logic [9:0]  index;
    logic [7:0]  value;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] lc;
    logic [16:0] le;
    logic [10:0] rcv;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    int          cfg;      // skip length to load before this row, -1 keeps it
    logic [7:0]  b;
    logic        first;
    logic        last;
    logic        lead;
    logic        typed;
    result_t     want;
  } dir_row_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [7:0]  frame_byte;
  logic        frame_first, frame_last, leading_frame;
  logic        out_valid, out_ready;
  logic        result_kind;
  logic [9:0]  data_index;
  logic [7:0]  data_value;
  logic [7:0]  class_byte, instruction_byte, param_one, param_two;
  logic [15:0] command_length;
  logic [16:0] response_length;
  logic [10:0] received_length;
  logic [2:0]  frame_status;
  logic        last_of_run;

  apdu_frame_reassembler u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .frame_byte(frame_byte),
    .frame_first(frame_first), .frame_last(frame_last), .leading_frame(leading_frame),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .data_index(data_index), .data_value(data_value), .class_byte(class_byte),
    .instruction_byte(instruction_byte), .param_one(param_one), .param_two(param_two),
    .command_length(command_length), .response_length(response_length),
    .received_length(received_length), .frame_status(frame_status),
    .last_of_run(last_of_run)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [3:0]  skip_len;
  logic [7:0]  fr_pos;
  logic        fr_leading;
  logic [31:0] apdu_hdr;
  logic [15:0] len_word;
  logic        len_ext;
  logic [15:0] apdu_lc;
  logic [16:0] apdu_le;
  logic [10:0] data_count;
  logic [7:0]  extra_count;
  logic [15:0] extra_bytes;
  logic [2:0]  fr_status;
  logic        step_has_write;
  result_t     step_write;

  result_t     apdu_results_due[$];
  int          error_count = 0;
  int          in_count = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  logic        typed_now = 1'b0;
  result_t     typed_want = '0;
  dir_row_t    dir_rows[$];

  function automatic result_t summary_of(input logic [7:0] cla, input logic [7:0] ins,
                                         input logic [7:0] p1, input logic [7:0] p2,
                                         input logic [15:0] lc, input logic [16:0] le,
                                         input logic [10:0] rcv, input logic [2:0] st);
    result_t r;
    r = '0;
    r.kind = afr_pkg::KindSummary;
    r.cla = cla; r.ins = ins; r.p1 = p1; r.p2 = p2;
    r.lc = lc; r.le = le; r.rcv = rcv; r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic string fmt(input result_t r);
    return $sformatf("kind=%0d idx=%0d val=%h hdr=%h%h%h%h lc=%0d le=%0d rcv=%0d st=%0d last=%0d",
                     r.kind, r.index, r.value, r.cla, r.ins, r.p1, r.p2, r.lc, r.le, r.rcv,
                     r.status, r.last);
  endfunction

  function automatic logic [7:0] rand8z();
    return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic raise_to(input logic [2:0] code);
    if (code > fr_status) fr_status = code;
  endtask

  task automatic store_data_byte(input logic [7:0] b);
    if (data_count < afr_pkg::MaxDataBytes) begin
      step_has_write = 1'b1;
      step_write = '0;
      step_write.kind = afr_pkg::KindData;
      step_write.index = data_count[9:0];
      step_write.value = b;
      data_count++;
    end else begin
      raise_to(afr_pkg::StOverflow);
    end
  endtask

  task automatic track_apdu_byte(input logic [7:0] b, input logic f, input logic l,
                                 input logic ld);
    int p, s;
    step_has_write = 1'b0;
    if (f) begin
      fr_pos = '0;
      fr_leading = ld;
      extra_count = '0;
      extra_bytes = '0;
      fr_status = afr_pkg::StOk;
      if (ld) begin
        apdu_hdr = '0; len_word = '0; len_ext = 1'b0;
        apdu_lc = '0; apdu_le = '0; data_count = '0;
      end
    end
    p = fr_pos;
    s = skip_len;
    if (fr_leading) begin
      if (p < s) begin
        if (l) raise_to(afr_pkg::StMalformed);
      end else if (p < s + 4) begin
        apdu_hdr[8 * (3 - (p - s)) +: 8] = b;
        if (l) raise_to((p == s + 3) ? afr_pkg::StHeaderOnly : afr_pkg::StMalformed);
      end else if (p == s + 4) begin
        // length byte that closes the frame is Le, otherwise Lc
        if (b != 8'h00) begin
          if (l) begin
            apdu_le = {9'd0, b};
            apdu_lc = '0;
          end else begin
            apdu_lc = {8'd0, b};
          end
        end else if (l) begin
          apdu_le = LeShortZero;
          apdu_lc = '0;
        end else begin
          len_ext = 1'b1;
        end
      end else if (len_ext && p == s + 5) begin
        len_word = {b, 8'h00};
        if (l) raise_to(afr_pkg::StMalformed);
      end else if (len_ext && p == s + 6) begin
        len_word[7:0] = b;
        if (l) begin
          apdu_lc = '0;
          apdu_le = (len_word != 16'h0) ? {1'b0, len_word} : LeExtZero;
        end else begin
          apdu_lc = len_word;
        end
      end else begin
        store_data_byte(b);
      end
    end else if (p != 0) begin
      if (data_count < apdu_lc) begin
        store_data_byte(b);
      end else begin
        if (extra_count != 8'hFF) extra_count++;
        extra_bytes = {extra_bytes[7:0], b};
      end
    end
    if (l && !fr_leading) begin
      if (extra_count == 8'd1)
        apdu_le = (extra_bytes[7:0] != 8'h0) ? {9'd0, extra_bytes[7:0]} : LeShortZero;
      else if (extra_count == 8'd2)
        apdu_le = (extra_bytes != 16'h0) ? {1'b0, extra_bytes} : LeExtZero;
      else if (extra_count > 8'd2)
        raise_to(afr_pkg::StUnknownLe);
    end
    if (fr_pos != 8'hFF) fr_pos++;
    if (step_has_write) begin
      step_write.last = !l;
      apdu_results_due.push_back(step_write);
    end
    if (l)
      apdu_results_due.push_back(summary_of(apdu_hdr[31:24], apdu_hdr[23:16], apdu_hdr[15:8],
                                            apdu_hdr[7:0], apdu_lc, apdu_le, data_count,
                                            fr_status));
  endtask

  // input and output transfers, register writes
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      skip_len = afr_pkg::SkipReset;
      fr_pos = '0; fr_leading = 1'b0; apdu_hdr = '0; len_word = '0; len_ext = 1'b0;
      apdu_lc = '0; apdu_le = '0; data_count = '0; extra_count = '0; extra_bytes = '0;
      fr_status = afr_pkg::StOk;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SkipAddr) skip_len = pwdata[3:0];
      if (in_valid && in_ready) begin
        track_apdu_byte(frame_byte, frame_first, frame_last, leading_frame);
        if (typed_now) apdu_results_due[apdu_results_due.size() - 1] = typed_want;
        in_count++;
      end
      if (out_valid && out_ready) begin
        got.kind = result_kind;       got.index = data_index;    got.value = data_value;
        got.cla = class_byte;         got.ins = instruction_byte;
        got.p1 = param_one;           got.p2 = param_two;
        got.lc = command_length;      got.le = response_length;  got.rcv = received_length;
        got.status = frame_status;    got.last = last_of_run;
        if (apdu_results_due.size() == 0) begin
          note_error($sformatf("unexpected result %s", fmt(got)));
        end else begin
          want = apdu_results_due.pop_front();
          if (got !== want)
            note_error($sformatf("mismatch\n  expected %s\n  actual   %s", fmt(want), fmt(got)));
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs the block up
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && in_count >= 200) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge with in_valid low, returns the same way
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l, input logic ld);
    while ($urandom_range(99) < tx_idle) @(negedge clk);
    in_valid = 1'b1;
    frame_byte = b;
    frame_first = f;
    frame_last = l;
    leading_frame = ld;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_frame(input byte_q_t fr, input logic lead);
    foreach (fr[i])
      send_byte(fr[i], i == 0, i == fr.size() - 1, (i == 0) ? lead : 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (apdu_results_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_skip(input logic [3:0] v);
    logic [31:0] rd;
    wait_drained();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = SkipAddr;
    pwdata = {$urandom} & 32'hFFFF_FFF0 | {28'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if (rd !== {28'd0, v}) note_error($sformatf("skip readback %h, wrote %h", rd, v));
  endtask

  task automatic push_prefix(ref byte_q_t fr);
    fr = {};
    repeat (skip_len) fr.push_back(8'($urandom));
    repeat (4) fr.push_back(8'($urandom));
  endtask

  // well-formed command: Le only, or Lc with data split over leading and continuation frames
  task automatic send_command();
    byte_q_t fr;
    int form, lc, k, ex, rest, cut;
    push_prefix(fr);
    form = $urandom_range(3);
    if (form == 0) begin
      fr.push_back(rand8z());
      send_frame(fr, 1'b1);
    end else if (form == 1) begin
      fr.push_back(8'h00);
      fr.push_back(rand8z());
      fr.push_back(rand8z());
      send_frame(fr, 1'b1);
    end else begin
      lc = $urandom_range(1, 12);
      if (form == 2) begin
        fr.push_back(8'(lc));
      end else begin
        fr.push_back(8'h00);
        fr.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
        fr.push_back(8'(lc));
      end
      k = $urandom_range(1, lc);
      ex = $urandom_range(9) / 3;
      repeat (k) fr.push_back(8'($urandom));
      send_frame(fr, 1'b1);
      rest = lc - k + ex;
      if (rest > 0 || $urandom_range(3) == 0) begin
        cut = $urandom_range(0, rest);
        fr = {8'($urandom)};
        repeat (cut) fr.push_back(rand8z());
        send_frame(fr, 1'b0);
        if (rest > cut) begin
          fr = {8'($urandom)};
          repeat (rest - cut) fr.push_back(rand8z());
          send_frame(fr, 1'b0);
        end
      end
    end
  endtask

  // truncated leading frames, stray bytes and bare continuation frames
  task automatic send_broken();
    byte_q_t fr;
    int n;
    case ($urandom_range(2))
      0: begin
        n = $urandom_range(1, skip_len + 7);
        fr = {};
        repeat (n) fr.push_back(8'($urandom));
        if (n > skip_len + 4 && $urandom_range(1) == 0) fr[skip_len + 4] = 8'h00;
        send_frame(fr, 1'b1);
      end
      1: begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
      default: begin
        fr = {8'($urandom)};
        repeat ($urandom_range(1, 5)) fr.push_back(rand8z());
        send_frame(fr, 1'b0);
        if ($urandom_range(1) == 0) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0);
      end
    endcase
  endtask

  // extended Lc above the buffer size: the leading frame runs past the buffer,
  // then continuation bytes still count as data
  task automatic send_big_lc();
    byte_q_t fr;
    push_prefix(fr);
    fr.push_back(8'h00);
    fr.push_back(8'h04);
    fr.push_back(8'($urandom_range(1, 255)));
    repeat (afr_pkg::MaxDataBytes + 6) fr.push_back(8'($urandom));
    send_frame(fr, 1'b1);
    repeat (2) begin
      fr = {8'($urandom)};
      repeat (8) fr.push_back(8'($urandom));
      send_frame(fr, 1'b0);
    end
  endtask

  function automatic dir_row_t row(input int cfg, input logic [7:0] b, input logic f,
                                   input logic l, input logic ld);
    dir_row_t r;
    r = '0;
    r.cfg = cfg; r.b = b; r.first = f; r.last = l; r.lead = ld;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input int cfg, input logic [7:0] b, input logic f,
                                         input logic l, input logic ld, input result_t want);
    dir_row_t r;
    r = row(cfg, b, f, l, ld);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  initial begin
    int target;
    logic [3:0] v;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; frame_byte = '0; frame_first = 1'b0; frame_last = 1'b0;
    leading_frame = 1'b0;

    // one-byte leading frame ends inside the transport header
    dir_rows.push_back(typed_row(-1, 8'hFF, 1, 1, 1,
                                 summary_of(0, 0, 0, 0, 0, 0, 0, afr_pkg::StMalformed)));
    // header only
    dir_rows.push_back(row(0, 8'h00, 1, 0, 1));
    dir_rows.push_back(row(-1, 8'hFF, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'hA5, 0, 0, 0));
    dir_rows.push_back(typed_row(-1, 8'h5A, 0, 1, 0,
                                 summary_of(8'h00, 8'hFF, 8'hA5, 8'h5A, 0, 0, 0,
                                            afr_pkg::StHeaderOnly)));
    // lone zero length byte closes the frame: short Le of 256
    dir_rows.push_back(row(-1, 8'h11, 1, 0, 1));
    dir_rows.push_back(row(-1, 8'h22, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h33, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h44, 0, 0, 0));
    dir_rows.push_back(typed_row(-1, 8'h00, 0, 1, 0,
                                 summary_of(8'h11, 8'h22, 8'h33, 8'h44, 0, 256, 0,
                                            afr_pkg::StOk)));
    // extended field cut after the high byte
    dir_rows.push_back(row(-1, 8'h01, 1, 0, 1));
    dir_rows.push_back(row(-1, 8'h02, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h03, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h04, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h00, 0, 0, 0));
    dir_rows.push_back(typed_row(-1, 8'h00, 0, 1, 0,
                                 summary_of(8'h01, 8'h02, 8'h03, 8'h04, 0, 0, 0,
                                            afr_pkg::StMalformed)));
    // continuation with three excess bytes, then a byte without a first mark
    dir_rows.push_back(row(-1, 8'h00, 1, 0, 0));
    dir_rows.push_back(row(-1, 8'h01, 0, 0, 1));
    dir_rows.push_back(row(-1, 8'h02, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h03, 0, 1, 0));
    dir_rows.push_back(row(-1, 8'h7E, 0, 1, 1));
    // extended Lc of one, then two zero excess bytes: Le of 65536
    dir_rows.push_back(row(-1, 8'h80, 1, 0, 1));
    dir_rows.push_back(row(-1, 8'h2A, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h00, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'hFF, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h00, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h00, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'h01, 0, 0, 0));
    dir_rows.push_back(row(-1, 8'hAB, 0, 1, 0));
    dir_rows.push_back(row(-1, 8'hEE, 1, 0, 0));
    dir_rows.push_back(row(-1, 8'h00, 0, 0, 0));
    dir_rows.push_back(typed_row(-1, 8'h00, 0, 1, 0,
                                 summary_of(8'h80, 8'h2A, 8'h00, 8'hFF, 1, 17'h10000, 1,
                                            afr_pkg::StOk)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle = 20;
    rx_idle = 55;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) set_skip(dir_rows[i].cfg[3:0]);
      typed_now = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      send_byte(dir_rows[i].b, dir_rows[i].first, dir_rows[i].last, dir_rows[i].lead);
    end
    typed_now = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle = 20; rx_idle = 55; end
        1: begin tx_idle = 55; rx_idle = 20; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      case (ph)
        0, 5: v = 4'd15;
        2: v = 4'd1;
        3: v = 4'd0;
        default: v = 4'($urandom_range(2, 14));
      endcase
      set_skip(v);
      target = in_count + 85;
      while (in_count < target) begin
        if ($urandom_range(3) != 0) send_command();
        else send_broken();
      end
      if (ph == 5) send_big_lc();
    end

    while (apdu_results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/afr_pkg.sv
sv/afr_front.sv
sv/afr_queue.sv
sv/afr_back.sv
sv/apdu_frame_reassembler.sv
bench/apdu_frame_reassembler_test.sv
